// ----- hw/rtl/phlr_pkg.sv -----
// Types and codes shared by the per-host layer resync block.
package phlr_pkg;

    localparam int CFG_W = 4;

    typedef enum logic [2:0] {
        KIND_LINK_DOWN  = 3'd0,
        KIND_LINK_UP    = 3'd1,
        KIND_ACTIVE     = 3'd2,
        KIND_CLEARED    = 3'd3,
        KIND_DESELECTED = 3'd4,
        KIND_SELECTED   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] profile;
        logic       ble_now;
        logic       alt_now;
    } evt_beat_t;

    typedef struct packed {
        action_t action;
        logic    profile_link_up;
    } res_beat_t;

endpackage

// ----- hw/rtl/phlr_step.sv -----
// Next-state and result logic for one event beat.
module phlr_step #(
    parameter int MAX_PROFILES = 8,
    parameter int IDX_W        = 3,
    parameter int CNT_W        = 4
) (
    input  phlr_pkg::evt_beat_t     evt,
    input  logic [CNT_W-1:0]        count,
    input  logic [MAX_PROFILES-1:0] ralt_cur,
    input  logic [MAX_PROFILES-1:0] known_cur,
    input  logic [MAX_PROFILES-1:0] linked_cur,
    input  logic [IDX_W-1:0]        active_cur,
    input  logic                    owner_valid_cur,
    input  logic [IDX_W-1:0]        owner_cur,
    input  logic                    transport_cur,
    output logic [MAX_PROFILES-1:0] ralt_nxt,
    output logic [MAX_PROFILES-1:0] known_nxt,
    output logic [MAX_PROFILES-1:0] linked_nxt,
    output logic [IDX_W-1:0]        active_nxt,
    output logic                    owner_valid_nxt,
    output logic [IDX_W-1:0]        owner_nxt,
    output logic                    transport_nxt,
    output phlr_pkg::res_beat_t     res
);

    always_comb
    begin
        logic [MAX_PROFILES-1:0] ralt;
        logic [MAX_PROFILES-1:0] known;
        logic [MAX_PROFILES-1:0] linked;
        logic [IDX_W-1:0]        act;
        logic                    ov;
        logic [IDX_W-1:0]        own;
        logic                    ton;
        logic                    in_range;
        logic [IDX_W-1:0]        p;
        logic                    do_settle;
        logic                    sel_linked;
        logic                    sel_known;
        logic                    sel_alt;
        logic                    p_linked;
        phlr_pkg::action_t       act_code;

        ralt      = ralt_cur;
        known     = known_cur;
        linked    = linked_cur;
        act       = active_cur;
        ov        = owner_valid_cur;
        own       = owner_cur;
        ton       = transport_cur;
        in_range  = evt.profile < 8'(count);
        p         = evt.profile[IDX_W-1:0];
        do_settle = 1'b0;
        act_code  = phlr_pkg::ACT_NONE;
        sel_linked = 1'b0;
        sel_known  = 1'b0;
        sel_alt    = 1'b0;
        p_linked   = 1'b0;

        // transport reconcile: leaving saves the owner's on-screen language
        if (evt.ble_now != ton)
        begin
            if (!evt.ble_now && ov)
            begin
                for (int i = 0; i < MAX_PROFILES; i++)
                begin
                    if (IDX_W'(i) == own)
                    begin
                        ralt[i]  = evt.alt_now;
                        known[i] = 1'b1;
                    end
                end
                ov = 1'b0;
            end
            ton = evt.ble_now;
        end

        case (evt.kind)
            phlr_pkg::KIND_LINK_DOWN:
            begin
                if (in_range)
                begin
                    for (int i = 0; i < MAX_PROFILES; i++)
                    begin
                        if (IDX_W'(i) == p)
                        begin
                            linked[i] = 1'b0;
                            if (ov && own == p)
                            begin
                                ralt[i]  = evt.alt_now;
                                known[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            phlr_pkg::KIND_LINK_UP:
            begin
                if (in_range)
                begin
                    for (int i = 0; i < MAX_PROFILES; i++)
                    begin
                        if (IDX_W'(i) == p)
                            linked[i] = 1'b1;
                    end
                    do_settle = 1'b1;
                end
            end
            phlr_pkg::KIND_ACTIVE:
            begin
                if (in_range)
                begin
                    if (p != act)
                    begin
                        if (ov && own == act)
                        begin
                            for (int i = 0; i < MAX_PROFILES; i++)
                            begin
                                if (IDX_W'(i) == act)
                                begin
                                    ralt[i]  = evt.alt_now;
                                    known[i] = 1'b1;
                                end
                            end
                        end
                        ov  = 1'b0;
                        act = p;
                    end
                    do_settle = 1'b1;
                end
            end
            phlr_pkg::KIND_CLEARED:
            begin
                if (in_range)
                begin
                    for (int i = 0; i < MAX_PROFILES; i++)
                    begin
                        if (IDX_W'(i) == p)
                        begin
                            ralt[i]   = 1'b0;
                            known[i]  = 1'b0;
                            linked[i] = 1'b0;
                        end
                    end
                    if (ov && own == p)
                        ov = 1'b0;
                end
            end
            phlr_pkg::KIND_SELECTED:
            begin
                do_settle = 1'b1;
            end
            default:
            begin
                do_settle = 1'b0;
            end
        endcase

        // decision for the active profile
        for (int i = 0; i < MAX_PROFILES; i++)
        begin
            if (IDX_W'(i) == act)
            begin
                sel_linked = linked[i];
                sel_known  = known[i];
                sel_alt    = ralt[i];
            end
        end
        if (do_settle && ton && (CNT_W'(act) < count) && sel_linked && !(ov && own == act))
        begin
            ov  = 1'b1;
            own = act;
            if (!sel_known)
            begin
                for (int i = 0; i < MAX_PROFILES; i++)
                begin
                    if (IDX_W'(i) == act)
                    begin
                        known[i] = 1'b1;
                        ralt[i]  = 1'b0;
                    end
                end
                act_code = phlr_pkg::ACT_CLEAR;
            end
            else
            begin
                act_code = sel_alt ? phlr_pkg::ACT_SET : phlr_pkg::ACT_CLEAR;
            end
        end

        for (int i = 0; i < MAX_PROFILES; i++)
        begin
            if (IDX_W'(i) == p)
                p_linked = linked[i];
        end

        ralt_nxt            = ralt;
        known_nxt           = known;
        linked_nxt          = linked;
        active_nxt          = act;
        owner_valid_nxt     = ov;
        owner_nxt           = own;
        transport_nxt       = ton;
        res.action          = act_code;
        res.profile_link_up = in_range && p_linked;
    end

endmodule

// ----- hw/rtl/per_host_layer_resync_core.sv -----
// Top level of the per-host layer resync block: event register, state and result register.
// Accepts one event beat per clock while the result side keeps up. Each event goes through
// an input register, then a single pass of indexed flag updates and the layer decision into
// the result register, and a result-side stall can hold it in the input register;
// per-profile flags live in flip-flops, so back-to-back events see each other's updates.
// The user must write the profile count through the cfg channel (clamped to MAX_PROFILES)
// only while idle; the block itself does not enforce it.
module per_host_layer_resync_core #(
    parameter int MAX_PROFILES = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           evt_valid,
    output logic                           evt_ready,
    input  phlr_pkg::evt_beat_t            evt,
    output logic                           res_valid,
    input  logic                           res_ready,
    output phlr_pkg::res_beat_t            res,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [phlr_pkg::CFG_W-1:0]     cfg_data
);

    localparam int IDX_W     = (MAX_PROFILES > 1) ? $clog2(MAX_PROFILES) : 1;
    localparam int CNT_W     = $clog2(MAX_PROFILES + 1);
    localparam int RST_COUNT = (MAX_PROFILES < 8) ? MAX_PROFILES : 8;

    logic                    in_valid_reg;
    phlr_pkg::evt_beat_t     in_beat_reg;
    logic                    res_valid_reg;
    phlr_pkg::res_beat_t     res_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [MAX_PROFILES-1:0] ralt_reg;
    logic [MAX_PROFILES-1:0] known_reg;
    logic [MAX_PROFILES-1:0] linked_reg;
    logic [IDX_W-1:0]        active_reg;
    logic                    owner_valid_reg;
    logic [IDX_W-1:0]        owner_reg;
    logic                    transport_reg;

    logic [MAX_PROFILES-1:0] ralt_next;
    logic [MAX_PROFILES-1:0] known_next;
    logic [MAX_PROFILES-1:0] linked_next;
    logic [IDX_W-1:0]        active_next;
    logic                    owner_valid_next;
    logic [IDX_W-1:0]        owner_next;
    logic                    transport_next;
    phlr_pkg::res_beat_t     res_next;
    logic [CNT_W-1:0]        count_next;

    logic advance;

    assign advance   = in_valid_reg && (!res_valid_reg || res_ready);
    assign evt_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign count_next = (int'(cfg_data) > MAX_PROFILES) ? CNT_W'(MAX_PROFILES)
                                                         : CNT_W'(cfg_data);

    phlr_step #(
        .MAX_PROFILES (MAX_PROFILES),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_step (
        .evt             (in_beat_reg),
        .count           (count_reg),
        .ralt_cur        (ralt_reg),
        .known_cur       (known_reg),
        .linked_cur      (linked_reg),
        .active_cur      (active_reg),
        .owner_valid_cur (owner_valid_reg),
        .owner_cur       (owner_reg),
        .transport_cur   (transport_reg),
        .ralt_nxt        (ralt_next),
        .known_nxt       (known_next),
        .linked_nxt      (linked_next),
        .active_nxt      (active_next),
        .owner_valid_nxt (owner_valid_next),
        .owner_nxt       (owner_next),
        .transport_nxt   (transport_next),
        .res             (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            count_reg       <= CNT_W'(RST_COUNT);
            ralt_reg        <= '0;
            known_reg       <= '0;
            linked_reg      <= '0;
            active_reg      <= '0;
            owner_valid_reg <= 1'b0;
            owner_reg       <= '0;
            transport_reg   <= 1'b0;
        end
        else
        begin
            if (evt_ready)
                in_valid_reg <= evt_valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
            if (cfg_valid)
                count_reg <= count_next;
            if (advance)
            begin
                ralt_reg        <= ralt_next;
                known_reg       <= known_next;
                linked_reg      <= linked_next;
                active_reg      <= active_next;
                owner_valid_reg <= owner_valid_next;
                owner_reg       <= owner_next;
                transport_reg   <= transport_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (evt_ready && evt_valid)
            in_beat_reg <= evt;
        if (advance)
            res_reg <= res_next;
    end

endmodule
